>>> rtl/core/ssfw_pkg.sv
// Shared types, constants and glyph helpers for the score frame writer.
`default_nettype none

package ssfw_pkg;

  localparam int unsigned Digits     = 6;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPTR_W     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCNT_W     = $clog2(QueueDepth + 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 2'd1;

  localparam logic [7:0] BYTE_DATA_CMD  = 8'h40;
  localparam logic [7:0] BYTE_ADDR_CMD  = 8'hC0;
  localparam logic [7:0] BYTE_DISP_CTRL = 8'h88;
  localparam logic [9:0] SCORE_MAX      = 10'd999;

  // byte slots within one nine-byte run
  localparam logic [3:0] SLOT_DATA_CMD    = 4'd0;
  localparam logic [3:0] SLOT_ADDR_CMD    = 4'd1;
  localparam logic [3:0] SLOT_DIGIT_FIRST = 4'd2;
  localparam logic [3:0] SLOT_DIGIT_LAST  = 4'd7;
  localparam logic [3:0] SLOT_DISP_CTRL   = 4'd8;

  typedef logic [7:0] glyph_t;

  typedef struct packed {
    glyph_t [Digits-1:0] digits;
    logic   [2:0]        bright;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_req_t;

  function automatic glyph_t glyph_of(input logic [3:0] d);
    glyph_t g;
    case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // A<->D, B<->E, C<->F; G and DP stay
  function automatic glyph_t turn_glyph(input glyph_t g);
    return {g[7:6], g[2:0], g[5:3]};
  endfunction

  // Saturate at 999, split into decimal digits by reciprocal multiplies,
  // blank leading zeros. Element 0 is the hundreds digit.
  function automatic logic [2:0][7:0] draw_score(input logic show, input logic [15:0] score);
    logic [9:0]       sat;
    logic [15:0]      p100;
    logic [17:0]      p10;
    logic [3:0]       hund;
    logic [6:0]       tens_all;
    logic [6:0]       t_rem;
    logic [9:0]       o_rem;
    logic [2:0][7:0]  r;
    sat      = (score > 16'd999) ? SCORE_MAX : score[9:0];
    p100     = 16'(sat) * 16'd41;
    hund     = p100[15:12];
    p10      = 18'(sat) * 18'd205;
    tens_all = p10[17:11];
    t_rem    = tens_all - (7'(hund) * 7'd10);
    o_rem    = sat - (10'(tens_all) * 10'd10);
    r        = '0;
    if (show) begin
      if (sat >= 10'd100) r[0] = glyph_of(hund);
      if (sat >= 10'd10)  r[1] = glyph_of(t_rem[3:0]);
      r[2] = glyph_of(o_rem[3:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/seven_segment_score_frame_writer.sv
// Top level of the seven-segment score frame writer.
//
//  channel   direction  handshake             payload
//  request   in         push_i / full_o       show_left_i score_left_i show_right_i score_right_i
//  bus byte  out        empty_o / pop_i       bus_byte_o frame_start_o frame_end_o last_o
//  config    in         cfg_we_i (no wait)    cfg_idx_i cfg_wdata_i
//
// A request is drawn as it is accepted and compared in the cycle after; one request per
// cycle is absorbed while the two-entry frame queue has room.
// A changed request yields nine bytes, one per cycle with pop_i held: the back
// end's byte counter sets that rate. An unchanged request yields nothing.
// full_o rises only when a changed request waits on a full frame queue.
// Reset clears the queue, the stored digits and the registers
// (rotation off, brightness 7).
`default_nettype none

module seven_segment_score_frame_writer
  import ssfw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic                  show_left_i,
  input  wire logic [15:0]           score_left_i,
  input  wire logic                  show_right_i,
  input  wire logic [15:0]           score_right_i,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output logic [7:0]                 bus_byte_o,
  output logic                       frame_start_o,
  output logic                       frame_end_o,
  output logic                       last_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic       rotate_q;
  logic [2:0] bright_q;
  frame_req_t enq;
  frame_req_t head;
  logic       q_full;
  logic       deq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotate_q <= 1'b0;
      bright_q <= 3'd7;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROTATE: rotate_q <= cfg_wdata_i[0];
        REG_BRIGHT: bright_q <= cfg_wdata_i[2:0];
        default:    rotate_q <= rotate_q;
      endcase
    end
  end

  ssfw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .show_left_i   (show_left_i),
    .score_left_i  (score_left_i),
    .show_right_i  (show_right_i),
    .score_right_i (score_right_i),
    .rotate_i      (rotate_q),
    .bright_i      (bright_q),
    .full_o        (full_o),
    .q_full_i      (q_full),
    .enq_o         (enq)
  );

  ssfw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .enq_i  (enq),
    .full_o (q_full),
    .deq_i  (deq),
    .head_o (head)
  );

  ssfw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .deq_o         (deq),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .bus_byte_o    (bus_byte_o),
    .frame_start_o (frame_start_o),
    .frame_end_o   (frame_end_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/ssfw_front.sv
// Front end: takes requests, draws and maps digits, drops unchanged frames.
`default_nettype none

module ssfw_front
  import ssfw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic        show_left_i,
  input  wire logic [15:0] score_left_i,
  input  wire logic        show_right_i,
  input  wire logic [15:0] score_right_i,
  input  wire logic        rotate_i,
  input  wire logic [2:0]  bright_i,
  output logic             full_o,
  input  wire logic        q_full_i,
  output frame_req_t       enq_o
);

  logic                valid_q;
  glyph_t [Digits-1:0] logical_q;
  glyph_t [Digits-1:0] logical_d;
  glyph_t [Digits-1:0] phys;
  glyph_t [Digits-1:0] shadow_q;
  logic                written_q;
  logic                changed;
  logic                advance;
  logic                enq_ok;

  assign logical_d[2:0] = draw_score(show_left_i, score_left_i);
  assign logical_d[5:3] = draw_score(show_right_i, score_right_i);

  always_comb begin
    for (int i = 0; i < Digits / 2; i++) begin
      if (rotate_i) begin
        phys[i]              = turn_glyph(logical_q[i + Digits / 2]);
        phys[i + Digits / 2] = turn_glyph(logical_q[i]);
      end else begin
        phys[i]              = logical_q[Digits / 2 - 1 - i];
        phys[i + Digits / 2] = logical_q[Digits - 1 - i];
      end
    end
  end

  assign changed     = !written_q || (phys != shadow_q);
  assign enq_o.valid = valid_q && changed;
  assign enq_o.frame = '{digits: phys, bright: bright_i};
  assign enq_ok      = enq_o.valid && !q_full_i;
  assign advance     = !valid_q || !changed || !q_full_i;
  assign full_o      = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      written_q <= 1'b0;
      shadow_q  <= '0;
    end else begin
      if (advance) valid_q <= push_i;
      if (enq_ok) begin
        shadow_q  <= phys;
        written_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && push_i) logical_q <= logical_d;
  end

  a_enq_marks_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |=> written_q) else $error("written flag not set after frame");
  a_enq_updates_shadow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |=> (shadow_q == $past(phys))) else $error("shadow digits not updated");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !advance) |=> valid_q) else $error("stalled request dropped");

endmodule

`default_nettype wire

>>> rtl/core/ssfw_queue.sv
// Short frame queue between the front and back ends.
`default_nettype none

module ssfw_queue
  import ssfw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire frame_req_t enq_i,
  output logic            full_o,
  input  wire logic       deq_i,
  output frame_req_t      head_o
);

  frame_t [QueueDepth-1:0] mem_q;
  logic [QPTR_W-1:0]       wr_q;
  logic [QPTR_W-1:0]       rd_q;
  logic [QCNT_W-1:0]       cnt_q;
  logic                    do_push;
  logic                    do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QueueDepth));
  assign do_push      = enq_i.valid && !full_o;
  assign do_pop       = deq_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.frame = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == QPTR_W'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == QPTR_W'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= enq_i.frame;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QueueDepth)) else $error("queue count overflow");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |-> !full_o) else $error("frame written into full queue");
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |-> head_o.valid) else $error("frame taken from empty queue");

endmodule

`default_nettype wire

>>> rtl/core/ssfw_back.sv
// Back end: streams one queued frame as nine bus bytes.
`default_nettype none

module ssfw_back
  import ssfw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire frame_req_t head_i,
  output logic            deq_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [7:0]      bus_byte_o,
  output logic            frame_start_o,
  output logic            frame_end_o,
  output logic            last_o
);

  logic [3:0] slot_q;
  logic [2:0] slot_off;
  logic       take;

  assign empty_o  = !head_i.valid;
  assign take     = pop_i && head_i.valid;
  assign deq_o    = take && (slot_q == SLOT_DISP_CTRL);
  assign slot_off = slot_q[2:0] - SLOT_DIGIT_FIRST[2:0];

  always_comb begin
    bus_byte_o    = 8'h00;
    frame_start_o = 1'b0;
    frame_end_o   = 1'b0;
    last_o        = 1'b0;
    unique case (slot_q) inside
      SLOT_DATA_CMD: begin
        bus_byte_o    = BYTE_DATA_CMD;
        frame_start_o = 1'b1;
        frame_end_o   = 1'b1;
      end
      SLOT_ADDR_CMD: begin
        bus_byte_o    = BYTE_ADDR_CMD;
        frame_start_o = 1'b1;
      end
      [SLOT_DIGIT_FIRST:SLOT_DIGIT_LAST]: begin
        bus_byte_o  = head_i.frame.digits[slot_off];
        frame_end_o = (slot_q == SLOT_DIGIT_LAST);
      end
      SLOT_DISP_CTRL: begin
        bus_byte_o    = BYTE_DISP_CTRL | {5'b0, head_i.frame.bright};
        frame_start_o = 1'b1;
        frame_end_o   = 1'b1;
        last_o        = 1'b1;
      end
      default: begin
        bus_byte_o = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SLOT_DATA_CMD;
    end else if (take) begin
      slot_q <= (slot_q == SLOT_DISP_CTRL) ? SLOT_DATA_CMD : slot_q + 1'b1;
    end
  end

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_DISP_CTRL) else $error("slot counter out of range");
  a_mid_run_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_q != SLOT_DATA_CMD) |-> head_i.valid) else $error("frame lost mid run");
  a_deq_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |-> (last_o && !empty_o)) else $error("dequeue before final byte");

endmodule

`default_nettype wire

>>> verif/seven_segment_score_frame_writer_test.sv
// Self-checking bench for the seven-segment score frame writer: directed and random requests.
`timescale 1ns / 1ps

module seven_segment_score_frame_writer_test;
  import ssfw_pkg::*;

  localparam int unsigned ClkHalf       = 4;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned ItemsPerPhase = 112;
  localparam int unsigned ConfigEvery   = 40;

  // indexes the block has no register for
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic        show_l;
    logic [15:0] score_l;
    logic        show_r;
    logic [15:0] score_r;
  } score_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       stop;
    logic       run_last;
  } bus_word_t;

  class frame_scoreboard;
    logic       rotate;
    logic [2:0] bright;
    glyph_t     shown [Digits];
    bit         written;
    bus_word_t  expected_bytes [$];
    int         errors;

    function new();
      rotate  = 1'b0;
      bright  = 3'd7;
      written = 1'b0;
      errors  = 0;
      foreach (shown[i]) shown[i] = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ROTATE: rotate = data[0];
        REG_BRIGHT: bright = data[2:0];
        default: ;
      endcase
    endfunction

    function glyph_t segments_of(int unsigned d);
      case (d)
        0: return 8'h3F;
        1: return 8'h06;
        2: return 8'h5B;
        3: return 8'h4F;
        4: return 8'h66;
        5: return 8'h6D;
        6: return 8'h7D;
        7: return 8'h07;
        8: return 8'h7F;
        default: return 8'h6F;
      endcase
    endfunction

    // hundreds in [23:16], tens in [15:8], ones in [7:0]; leading zeros blank
    function logic [23:0] score_glyphs(logic [15:0] score);
      int unsigned s;
      logic [23:0] g;
      s = (score > 16'd999) ? 999 : score;
      g = '0;
      if (s >= 100) g[23:16] = segments_of(s / 100);
      if (s >= 10) g[15:8] = segments_of((s / 10) % 10);
      g[7:0] = segments_of(s % 10);
      return g;
    endfunction

    function glyph_t half_turn(glyph_t g);
      return (g & 8'hC0) | ((g & 8'h07) << 3) | ((g >> 3) & 8'h07);
    endfunction

    function void push_word(logic [7:0] d, logic s, logic e, logic l);
      bus_word_t w;
      w = {d, s, e, l};
      expected_bytes.push_back(w);
    endfunction

    function void note_request(score_req_t r);
      logic [23:0] lg;
      logic [23:0] rg;
      glyph_t      logical [Digits];
      glyph_t      grid [Digits];
      bit          differs;
      lg = r.show_l ? score_glyphs(r.score_l) : 24'h0;
      rg = r.show_r ? score_glyphs(r.score_r) : 24'h0;
      logical[0] = lg[23:16]; logical[1] = lg[15:8]; logical[2] = lg[7:0];
      logical[3] = rg[23:16]; logical[4] = rg[15:8]; logical[5] = rg[7:0];
      for (int i = 0; i < 3; i++) begin
        if (rotate) begin
          grid[i]     = half_turn(logical[i + 3]);
          grid[i + 3] = half_turn(logical[i]);
        end else begin
          grid[i]     = logical[2 - i];
          grid[i + 3] = logical[5 - i];
        end
      end
      differs = !written;
      for (int i = 0; i < Digits; i++) if (grid[i] != shown[i]) differs = 1'b1;
      if (!differs) return;
      push_word(BYTE_DATA_CMD, 1'b1, 1'b1, 1'b0);
      push_word(BYTE_ADDR_CMD, 1'b1, 1'b0, 1'b0);
      for (int i = 0; i < Digits; i++) begin
        push_word(grid[i], 1'b0, i == Digits - 1, 1'b0);
        shown[i] = grid[i];
      end
      push_word(BYTE_DISP_CTRL | {5'b0, bright}, 1'b1, 1'b1, 1'b1);
      written = 1'b1;
    endfunction

    function void check_bus_byte(bus_word_t got);
      bus_word_t want;
      if (expected_bytes.size() == 0) begin
        $error("bus_byte: none expected, actual %h", got.data);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data !== want.data) begin
        $error("bus_byte: expected %h, actual %h", want.data, got.data);
        errors++;
      end
      if (got.start !== want.start) begin
        $error("frame_start: expected %b, actual %b", want.start, got.start);
        errors++;
      end
      if (got.stop !== want.stop) begin
        $error("frame_end: expected %b, actual %b", want.stop, got.stop);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("last: expected %b, actual %b", want.run_last, got.run_last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  push        = 1'b0;
  logic                  show_left   = 1'b0;
  logic [15:0]           score_left  = '0;
  logic                  show_right  = 1'b0;
  logic [15:0]           score_right = '0;
  logic                  pop         = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  full_o;
  logic                  empty_o;
  logic [7:0]            bus_byte_o;
  logic                  frame_start_o;
  logic                  frame_end_o;
  logic                  last_o;

  frame_scoreboard sb;
  int unsigned     tx_idle_pct  = 0;
  int unsigned     rx_stall_pct = 0;
  bit              hold_req     = 1'b0;
  int unsigned     hold_left    = 0;
  int unsigned     quiet_cycles = 0;
  score_req_t      last_req     = '0;

  seven_segment_score_frame_writer u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push_i        (push),
    .full_o        (full_o),
    .show_left_i   (show_left),
    .score_left_i  (score_left),
    .show_right_i  (show_right),
    .score_right_i (score_right),
    .empty_o       (empty_o),
    .pop_i         (pop),
    .bus_byte_o    (bus_byte_o),
    .frame_start_o (frame_start_o),
    .frame_end_o   (frame_end_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    #(ClkHalf) clk = 1'b1;
    #(ClkHalf) clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty_o)
      sb.check_bus_byte({bus_byte_o, frame_start_o, frame_end_o, last_o});
  end

  always @(posedge clk) begin
    if ((push && !full_o) || (pop && !empty_o) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input score_req_t r);
    @(negedge clk);
    push        <= 1'b1;
    show_left   <= r.show_l;
    score_left  <= r.score_l;
    show_right  <= r.show_r;
    score_right <= r.score_r;
    @(posedge clk);
    while (full_o) @(posedge clk);
    sb.note_request(r);
    last_req = r;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      push        <= 1'b0;
      show_left   <= 1'($urandom);
      score_left  <= 16'($urandom);
      show_right  <= 1'($urandom);
      score_right <= 16'($urandom);
    end
  endtask

  // unchanged requests leave no trace, so give the front end time to finish
  task automatic drain_and_settle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_score();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(9));
      1:       return 16'($urandom_range(99, 10));
      2:       return 16'($urandom_range(999, 100));
      3:       return 16'($urandom_range(65535, 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  // mix of repeats, same picture with other raw fields, and fresh scores
  function automatic score_req_t next_request(score_req_t prev);
    score_req_t  r;
    int unsigned roll;
    roll = $urandom_range(99);
    r    = prev;
    if (roll >= 35) begin
      r.show_l  = ($urandom_range(7) != 0);
      r.score_l = pick_score();
      r.show_r  = ($urandom_range(7) != 0);
      r.score_r = pick_score();
    end else if (roll >= 20) begin
      if (!r.show_l) r.score_l = 16'($urandom);
      else if (r.score_l >= 16'd999) r.score_l = 16'($urandom_range(65535, 999));
      if (!r.show_r) r.score_r = 16'($urandom);
      else if (r.score_r >= 16'd999) r.score_r = 16'($urandom_range(65535, 999));
    end
    return r;
  endfunction

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first request is always written, even when blank
    send_request('{1'b0, 16'd0, 1'b0, 16'd0});
    send_request('{1'b0, 16'd0, 1'b0, 16'd0});
    send_request('{1'b1, 16'd0, 1'b1, 16'd0});
    send_request('{1'b1, 16'd999, 1'b1, 16'd1000});
    send_request('{1'b1, 16'hFFFF, 1'b1, 16'd999});
    send_request('{1'b1, 16'd5, 1'b1, 16'd42});
    send_request('{1'b1, 16'd100, 1'b1, 16'd10});
    send_request('{1'b1, 16'd123, 1'b1, 16'd456});
    send_request('{1'b1, 16'd789, 1'b0, 16'hFFFF});
    send_request('{1'b0, 16'hFFFF, 1'b1, 16'd888});
    send_request('{1'b1, 16'h8000, 1'b1, 16'h7FFF});
    send_request('{1'b1, 16'd1, 1'b1, 16'd9});
    drain_and_settle();
    // brightness alone does not trigger a write
    write_register(REG_BRIGHT, 3'd0);
    send_request('{1'b1, 16'd1, 1'b1, 16'd9});
    send_request('{1'b1, 16'd2, 1'b1, 16'd9});
    drain_and_settle();
    write_register(REG_ROTATE, 3'd1);
    send_request('{1'b1, 16'd2, 1'b1, 16'd9});
    send_request('{1'b1, 16'd305, 1'b1, 16'd67});
    send_request('{1'b0, 16'd0, 1'b0, 16'd0});
    drain_and_settle();
    // upper bits ignored: this clears rotation; blank picture stays unchanged
    write_register(REG_ROTATE, 3'b110);
    send_request('{1'b0, 16'd0, 1'b0, 16'd0});
    drain_and_settle();
    write_register(REG_SPARE_LO, 3'd7);
    write_register(REG_SPARE_HI, 3'd5);
    send_request('{1'b1, 16'd7, 1'b1, 16'd0});
    drain_and_settle();
    write_register(REG_BRIGHT, 3'd7);
    write_register(REG_ROTATE, 3'd1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
      endcase
      // long receiver hold-off so the block fills and pushes back
      if (phase == 0) hold_req = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_request(next_request(last_req));
        if (n % ConfigEvery == ConfigEvery - 1) begin
          drain_and_settle();
          write_register(REG_ROTATE, 3'($urandom));
          write_register(REG_BRIGHT, 3'($urandom));
        end
      end
      drain_and_settle();
    end

    repeat (16) @(posedge clk);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ssfw_pkg.sv
rtl/core/ssfw_front.sv
rtl/core/ssfw_queue.sv
rtl/core/ssfw_back.sv
rtl/core/seven_segment_score_frame_writer.sv
verif/seven_segment_score_frame_writer_test.sv
